### sv/hdp_pkg.sv
package hdp_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int COORD_BITS_DEF = 16;

	localparam int FIELD_W = 16;
	localparam int DSQ_W   = 34;
	localparam int DIST_W  = 17;

	localparam logic [1:0] ST_VALID      = 2'd0;
	localparam logic [1:0] ST_ONE_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BOTH_EMPTY = 2'd2;

	typedef struct packed {
		logic                      req_type;
		logic signed [FIELD_W-1:0] point_re;
		logic signed [FIELD_W-1:0] point_im;
		logic                      last;
	} req_t;

	typedef struct packed {
		logic [DSQ_W-1:0]  dist_squared;
		logic [DIST_W-1:0] distance;
		logic [1:0]        status;
		logic              overflow;
	} res_t;

	typedef struct packed {
		logic       wr_a;
		logic       wr_b;
		logic       scan_vld;
		logic       scan_first;
		logic       scan_last;
		logic       clr_best;
		logic       root_go;
		logic [1:0] status;
		logic       overflow;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic root_done;
	} sts_t;

endpackage

### sv/hausdorff_distance_points.sv
// Symmetric Hausdorff distance of two planar point sets.
// Input: a beat is taken when start is high and busy is low. Each beat
// carries one point tagged for set A or B; up to MAX_POINTS per set are
// stored, further points are dropped and reported through overflow.
// Points load at one per cycle while busy stays low.
// A beat with last set closes the load (its own point is stored too) and
// raises busy. The pair scan then runs both directions through a 4-stage
// distance pipeline, one pair per cycle, 2*Na*Nb pairs in all. Busy also
// covers a setup state, the pipeline drain, the bit-per-cycle square root
// and the result register. When a set is empty the scan is skipped.
// Output: done is high for exactly one cycle with res valid; there is
// no back-pressure, the result must be taken in that cycle. busy falls
// in the same cycle as done, and the next load may begin then.
// Reset (arst_n low) clears point counts, overflow and control; stored
// points are not cleared, and only points of the current load are read.
module hausdorff_distance_points #(
	parameter int MAX_POINTS = hdp_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = hdp_pkg::COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  hdp_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output hdp_pkg::res_t res
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	hdp_pkg::cmd_t cmd;
	hdp_pkg::sts_t sts;
	logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;

	hdp_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_a_addr(rd_a_addr),
		.rd_b_addr(rd_b_addr)
	);

	hdp_dp #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_a_addr(rd_a_addr),
		.rd_b_addr(rd_b_addr),
		.sts      (sts),
		.done     (done),
		.res      (res)
	);

endmodule

### sv/hdp_isqrt.sv
module hdp_isqrt #(
	parameter int RW = 17
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [2*RW-1:0] rad,
	output logic            done,
	output logic [RW-1:0]   root
);

	localparam int W    = 2 * RW;
	localparam int REMW = RW + 3;
	localparam int KW   = $clog2(RW + 1);

	logic            run_q;
	logic            done_q;
	logic [KW-1:0]   k_q;
	logic [W-1:0]    rad_q;
	logic [REMW-1:0] rem_q;
	logic [RW-1:0]   root_q;

	logic [REMW-1:0] nrem;
	logic [REMW-1:0] trial;
	logic            fit;

	assign nrem  = {rem_q[REMW-3:0], rad_q[W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fit   = nrem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				k_q   <= KW'(RW - 1);
			end else if (run_q) begin
				k_q <= k_q - KW'(1);
				if (k_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[W-3:0], 2'b00};
			rem_q  <= fit ? (nrem - trial) : nrem;
			root_q <= {root_q[RW-2:0], fit};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### sv/hdp_dp.sv
module hdp_dp #(
	parameter int MAX_POINTS = hdp_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = hdp_pkg::COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hdp_pkg::req_t req,
	input  hdp_pkg::cmd_t cmd,
	input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] wr_addr,
	input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_a_addr,
	input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_b_addr,
	output hdp_pkg::sts_t sts,
	output logic          done,
	output hdp_pkg::res_t res
);

	localparam int C     = COORD_BITS;
	localparam int PW    = 2 * C;
	localparam int SUMW  = 2 * C + 1;
	localparam int RW    = C + 1;
	localparam int EXTW  = C + hdp_pkg::FIELD_W;

	logic [PW-1:0] mem_a [MAX_POINTS];
	logic [PW-1:0] mem_b [MAX_POINTS];

	logic [EXTW-1:0] re_ext;
	logic [EXTW-1:0] im_ext;
	logic [PW-1:0]   wdata;

	assign re_ext = {{C{1'b0}}, req.point_re};
	assign im_ext = {{C{1'b0}}, req.point_im};
	assign wdata  = {re_ext[C-1:0], im_ext[C-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.wr_a)
			mem_a[wr_addr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b)
			mem_b[wr_addr] <= wdata;
	end

	logic [PW-1:0] pa_s1, pb_s1;
	logic          vld_s1, first_s1, last_s1;

	always_ff @(posedge clk) begin
		pa_s1 <= mem_a[rd_a_addr];
		pb_s1 <= mem_b[rd_b_addr];
	end

	// difference and magnitude
	logic signed [C:0] dx, dy;
	logic [C:0]        mx, my;

	assign dx = $signed({pa_s1[PW-1], pa_s1[PW-1 -: C]}) - $signed({pb_s1[PW-1], pb_s1[PW-1 -: C]});
	assign dy = $signed({pa_s1[C-1], pa_s1[C-1:0]}) - $signed({pb_s1[C-1], pb_s1[C-1:0]});
	assign mx = dx[C] ? -dx : dx;
	assign my = dy[C] ? -dy : dy;

	logic [C-1:0] ax_s2, ay_s2;
	logic         vld_s2, first_s2, last_s2;
	logic [PW-1:0] sx_s3, sy_s3;
	logic          vld_s3, first_s3, last_s3;
	logic [SUMW-1:0] sum_s4;
	logic            vld_s4, first_s4, last_s4;

	always_ff @(posedge clk) begin
		ax_s2  <= mx[C-1:0];
		ay_s2  <= my[C-1:0];
		sx_s3  <= {{C{1'b0}}, ax_s2} * {{C{1'b0}}, ax_s2};
		sy_s3  <= {{C{1'b0}}, ay_s2} * {{C{1'b0}}, ay_s2};
		sum_s4 <= {1'b0, sx_s3} + {1'b0, sy_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; first_s1 <= 1'b0; last_s1 <= 1'b0;
			vld_s2 <= 1'b0; first_s2 <= 1'b0; last_s2 <= 1'b0;
			vld_s3 <= 1'b0; first_s3 <= 1'b0; last_s3 <= 1'b0;
			vld_s4 <= 1'b0; first_s4 <= 1'b0; last_s4 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_vld; first_s1 <= cmd.scan_first; last_s1 <= cmd.scan_last;
			vld_s2 <= vld_s1;       first_s2 <= first_s1;       last_s2 <= last_s1;
			vld_s3 <= vld_s2;       first_s3 <= first_s2;       last_s3 <= last_s2;
			vld_s4 <= vld_s3;       first_s4 <= first_s3;       last_s4 <= last_s3;
		end
	end

	assign sts.pipe_busy = vld_s1 | vld_s2 | vld_s3 | vld_s4;

	// nearest per row, largest over rows
	logic [SUMW-1:0] near_q, best_q, near_n;

	assign near_n = (first_s4 || sum_s4 < near_q) ? sum_s4 : near_q;

	always_ff @(posedge clk) begin
		if (cmd.clr_best)
			best_q <= '0;
		else if (vld_s4 && last_s4 && near_n > best_q)
			best_q <= near_n;
		if (vld_s4)
			near_q <= near_n;
	end

	logic [RW-1:0] root;
	logic          root_done;

	hdp_isqrt #(
		.RW(RW)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.root_go),
		.rad   ({1'b0, best_q}),
		.done  (root_done),
		.root  (root)
	);

	assign sts.root_done = root_done;

	logic [SUMW+hdp_pkg::DSQ_W-1:0] dsq_ext;
	logic [RW+hdp_pkg::DIST_W-1:0]  root_ext;

	assign dsq_ext  = {{hdp_pkg::DSQ_W{1'b0}}, best_q};
	assign root_ext = {{hdp_pkg::DIST_W{1'b0}}, root};

	hdp_pkg::res_t res_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= root_done;
	end

	always_ff @(posedge clk) begin
		if (root_done) begin
			res_q.dist_squared <= dsq_ext[hdp_pkg::DSQ_W-1:0];
			res_q.distance     <= root_ext[hdp_pkg::DIST_W-1:0];
			res_q.status       <= cmd.status;
			res_q.overflow     <= cmd.overflow;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (res_q.status == hdp_pkg::ST_VALID || res_q.dist_squared == '0))
		else $error("empty-set result carries a nonzero distance");

	a_pipe_quiet_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_go |-> !sts.pipe_busy)
		else $error("square root started while pair pipeline still busy");

endmodule

### sv/hdp_ctrl.sv
module hdp_ctrl #(
	parameter int MAX_POINTS = hdp_pkg::MAX_POINTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  hdp_pkg::req_t req,
	input  hdp_pkg::sts_t sts,
	output logic          busy,
	output hdp_pkg::cmd_t cmd,
	output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] wr_addr,
	output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_a_addr,
	output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_b_addr
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_ROOT  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic [CW-1:0] i_q, j_q;
	logic          dir_q;
	logic          ovf_q;
	logic [1:0]    stat_q;

	logic          accept;
	logic          room_a, room_b;
	logic [CW-1:0] nf, nt;
	logic          j_end, i_end;

	assign accept = start && state_q == S_LOAD;
	assign room_a = cnt_a_q < CW'(MAX_POINTS);
	assign room_b = cnt_b_q < CW'(MAX_POINTS);
	assign nf     = dir_q ? cnt_b_q : cnt_a_q;
	assign nt     = dir_q ? cnt_a_q : cnt_b_q;
	assign j_end  = j_q == nt - CW'(1);
	assign i_end  = i_q == nf - CW'(1);

	assign busy      = state_q != S_LOAD;
	assign wr_addr   = req.req_type ? cnt_b_q[AW-1:0] : cnt_a_q[AW-1:0];
	assign rd_a_addr = dir_q ? j_q[AW-1:0] : i_q[AW-1:0];
	assign rd_b_addr = dir_q ? i_q[AW-1:0] : j_q[AW-1:0];

	always_comb begin
		cmd            = '0;
		cmd.wr_a       = accept && !req.req_type && room_a;
		cmd.wr_b       = accept && req.req_type && room_b;
		cmd.scan_vld   = state_q == S_SCAN;
		cmd.scan_first = j_q == '0;
		cmd.scan_last  = j_end;
		cmd.clr_best   = state_q == S_PREP;
		cmd.root_go    = state_q == S_DRAIN && !sts.pipe_busy;
		cmd.status     = stat_q;
		cmd.overflow   = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			dir_q   <= 1'b0;
			ovf_q   <= 1'b0;
			stat_q  <= hdp_pkg::ST_VALID;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (cmd.wr_a)
							cnt_a_q <= cnt_a_q + CW'(1);
						if (cmd.wr_b)
							cnt_b_q <= cnt_b_q + CW'(1);
						if (!cmd.wr_a && !cmd.wr_b)
							ovf_q <= 1'b1;
						if (req.last)
							state_q <= S_PREP;
					end
				end
				S_PREP: begin
					i_q   <= '0;
					j_q   <= '0;
					dir_q <= 1'b0;
					if (cnt_a_q == '0 && cnt_b_q == '0) begin
						stat_q  <= hdp_pkg::ST_BOTH_EMPTY;
						state_q <= S_DRAIN;
					end else if (cnt_a_q == '0 || cnt_b_q == '0) begin
						stat_q  <= hdp_pkg::ST_ONE_EMPTY;
						state_q <= S_DRAIN;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (j_end) begin
						j_q <= '0;
						if (i_end) begin
							i_q <= '0;
							if (dir_q)
								state_q <= S_DRAIN;
							dir_q <= 1'b1;
						end else begin
							i_q <= i_q + CW'(1);
						end
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_DRAIN: begin
					if (!sts.pipe_busy)
						state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sts.root_done) begin
						state_q <= S_LOAD;
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						ovf_q   <= 1'b0;
						stat_q  <= hdp_pkg::ST_VALID;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (cnt_a_q != '0 && cnt_b_q != '0))
		else $error("pair scan with an empty set");

	a_root_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sts.root_done |-> state_q == S_ROOT)
		else $error("square root finished outside root wait");

	a_free_after_root: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(sts.root_done))
		else $error("block freed without a finished result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_a_q <= CW'(MAX_POINTS) && cnt_b_q <= CW'(MAX_POINTS))
		else $error("point count beyond capacity");

endmodule
